// ===== rtl/nnr_pkg.sv =====
// Shared constants for the nearest-neighbor resize core.
// Field widths, configuration register indexes and item mode codes.
// No dependencies.
package nnr_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int IN_DIM_W  = 7;
  localparam int OUT_DIM_W = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(3);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

endpackage

// ===== rtl/nearest_neighbor_resize_core.sv =====
// Top level of the nearest-neighbor resize core.
// Holds configuration, load address and output register; instantiates
// nnr_div, nnr_walk and nnr_store. Uses nnr_pkg.
//
// Load items (mode 0) write samples into the plane store in raster order,
// one transfer per cycle when in_stall is low. Fetch items (mode 1)
// return the next output pixel in raster order: the store read is
// registered and the result is flagged through rd_pend and out_valid,
// and the input side stalls while a fetch read is pending. Source
// positions are stepped incrementally from ratios computed once per
// configuration change: after a register write the input side stalls
// while the serial divider runs. Any register write also restarts the
// load and output raster positions. Reading a store entry never loaded
// is undefined.
module nearest_neighbor_resize_core
  import nnr_pkg::*;
#(
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_OUT_SIDE  = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SAMPLE_W-1:0]  pixel,
  output logic                 row_end,
  output logic                 plane_end
);

  localparam int DEPTH = MAX_IN_HEIGHT * MAX_IN_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IHW   = $clog2(MAX_IN_HEIGHT + 1);
  localparam int IWW   = $clog2(MAX_IN_WIDTH + 1);
  localparam int OSW   = $clog2(MAX_OUT_SIDE + 1);
  localparam int OPW   = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
  localparam int SCW   = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;

  logic [IN_DIM_W-1:0]  in_height, in_width;
  logic [OUT_DIM_W-1:0] out_height, out_width;
  logic [IHW-1:0]       eff_ih;
  logic [IWW-1:0]       eff_iw;
  logic [OSW-1:0]       eff_oh, eff_ow;

  logic                 cfg_hit, recalc, div_busy;
  logic [IWW-1:0]       q_w;
  logic [OSW-1:0]       r_h, r_w;
  logic [AW-1:0]        qh_iw, plane_last;

  logic                 in_xfer, load_go, fetch_go, rd_pend;
  logic [AW-1:0]        load_pos, rd_addr;
  logic                 rend, pend;

  // effective dimensions: zero reads as one, oversize saturates
  always_comb begin
    if (in_height == '0) eff_ih = IHW'(1);
    else if (32'(in_height) > 32'(MAX_IN_HEIGHT)) eff_ih = IHW'(MAX_IN_HEIGHT);
    else eff_ih = IHW'(in_height);
    if (in_width == '0) eff_iw = IWW'(1);
    else if (32'(in_width) > 32'(MAX_IN_WIDTH)) eff_iw = IWW'(MAX_IN_WIDTH);
    else eff_iw = IWW'(in_width);
    if (out_height == '0) eff_oh = OSW'(1);
    else if (32'(out_height) > 32'(MAX_OUT_SIDE)) eff_oh = OSW'(MAX_OUT_SIDE);
    else eff_oh = OSW'(out_height);
    if (out_width == '0) eff_ow = OSW'(1);
    else if (32'(out_width) > 32'(MAX_OUT_SIDE)) eff_ow = OSW'(MAX_OUT_SIDE);
    else eff_ow = OSW'(out_width);
  end

  assign cfg_hit = cfg_write && (cfg_index == REG_IN_HEIGHT || cfg_index == REG_IN_WIDTH ||
                                 cfg_index == REG_OUT_HEIGHT || cfg_index == REG_OUT_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height  <= IN_DIM_W'(1);
      in_width   <= IN_DIM_W'(1);
      out_height <= OUT_DIM_W'(1);
      out_width  <= OUT_DIM_W'(1);
      recalc     <= 1'b0;
    end else begin
      recalc <= cfg_hit;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IN_HEIGHT:  in_height  <= cfg_data[IN_DIM_W-1:0];
          REG_IN_WIDTH:   in_width   <= cfg_data[IN_DIM_W-1:0];
          REG_OUT_HEIGHT: out_height <= cfg_data[OUT_DIM_W-1:0];
          REG_OUT_WIDTH:  out_width  <= cfg_data[OUT_DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall = recalc || div_busy || rd_pend || (out_valid && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign load_go  = in_xfer && (mode == MODE_LOAD);
  assign fetch_go = in_xfer && (mode == MODE_FETCH);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_pos <= '0;
    end else if (load_go) begin
      load_pos <= (load_pos == plane_last) ? '0 : load_pos + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= fetch_go;
      if (rd_pend) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_go) begin
      row_end   <= rend;
      plane_end <= pend;
    end
  end

  nnr_div #(
    .IHW(IHW), .IWW(IWW), .OSW(OSW), .AW(AW)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (recalc),
    .eff_ih     (eff_ih),
    .eff_iw     (eff_iw),
    .eff_oh     (eff_oh),
    .eff_ow     (eff_ow),
    .busy       (div_busy),
    .r_h        (r_h),
    .q_w        (q_w),
    .r_w        (r_w),
    .qh_iw      (qh_iw),
    .plane_last (plane_last)
  );

  nnr_walk #(
    .IWW(IWW), .OSW(OSW), .OPW(OPW), .SCW(SCW), .AW(AW)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_hit),
    .step   (fetch_go),
    .eff_iw (eff_iw),
    .eff_oh (eff_oh),
    .eff_ow (eff_ow),
    .r_h    (r_h),
    .q_w    (q_w),
    .r_w    (r_w),
    .qh_iw  (qh_iw),
    .addr   (rd_addr),
    .rend   (rend),
    .pend   (pend)
  );

  nnr_store #(
    .DEPTH(DEPTH), .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (load_go),
    .waddr (load_pos),
    .wdata (sample),
    .re    (fetch_go),
    .raddr (rd_addr),
    .rdata (pixel)
  );

endmodule

// ===== rtl/nnr_store.sv =====
// Plane store: one synchronous RAM, one write port, one read port.
// Read data is registered and holds until the next read. Uses nnr_pkg.
module nnr_store
  import nnr_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nnr_div.sv =====
// Ratio setup unit: after a configuration change, divides in_width by
// out_width and in_height by out_height (restoring, one bit per cycle),
// then forms q_h*in_width and the last load address. No package use.
module nnr_div #(
  parameter int IHW = 7,
  parameter int IWW = 7,
  parameter int OSW = 13,
  parameter int AW  = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [IHW-1:0] eff_ih,
  input  logic [IWW-1:0] eff_iw,
  input  logic [OSW-1:0] eff_oh,
  input  logic [OSW-1:0] eff_ow,
  output logic           busy,
  output logic [OSW-1:0] r_h,
  output logic [IWW-1:0] q_w,
  output logic [OSW-1:0] r_w,
  output logic [AW-1:0]  qh_iw,
  output logic [AW-1:0]  plane_last
);

  localparam int DW  = (IHW > IWW) ? ((IHW > 2) ? IHW : 2) : ((IWW > 2) ? IWW : 2);
  localparam int CNW = $clog2(DW);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_SCALE = 3'b100
  } div_state_t;

  div_state_t     state, state_next;
  logic [CNW-1:0] cnt;
  logic [DW-1:0]  nh, nw;
  logic [OSW-1:0] remh, remw;
  logic [OSW:0]   remh_sh, remw_sh;
  logic           qbit_h, qbit_w;

  assign remh_sh = {remh, nh[DW-1]};
  assign remw_sh = {remw, nw[DW-1]};
  assign qbit_h  = (remh_sh >= {1'b0, eff_oh});
  assign qbit_w  = (remw_sh >= {1'b0, eff_ow});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  state_next = ST_IDLE;
      ST_DIV:   if (cnt == CNW'(DW - 1)) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    if (start) state_next = ST_DIV;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      nh         <= DW'(1);
      nw         <= DW'(1);
      remh       <= '0;
      remw       <= '0;
      qh_iw      <= AW'(1);
      plane_last <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        cnt  <= '0;
        nh   <= DW'(eff_ih);
        nw   <= DW'(eff_iw);
        remh <= '0;
        remw <= '0;
      end else if (state == ST_DIV) begin
        cnt  <= cnt + CNW'(1);
        nh   <= {nh[DW-2:0], qbit_h};
        nw   <= {nw[DW-2:0], qbit_w};
        remh <= qbit_h ? OSW'(remh_sh - {1'b0, eff_oh}) : OSW'(remh_sh);
        remw <= qbit_w ? OSW'(remw_sh - {1'b0, eff_ow}) : OSW'(remw_sh);
      end else if (state == ST_SCALE) begin
        qh_iw      <= AW'(nh * eff_iw);
        plane_last <= AW'(eff_ih * eff_iw - 1);
      end
    end
  end

  assign busy = (state != ST_IDLE);
  assign q_w  = IWW'(nw);
  assign r_h  = remh;
  assign r_w  = remw;

endmodule

// ===== rtl/nnr_walk.sv =====
// Output raster walker: tracks output row/column and steps the source
// row base and source column by quotient plus remainder carry.
// Takes its ratios from nnr_div. No package use.
module nnr_walk #(
  parameter int IWW = 7,
  parameter int OSW = 13,
  parameter int OPW = 12,
  parameter int SCW = 6,
  parameter int AW  = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           step,
  input  logic [IWW-1:0] eff_iw,
  input  logic [OSW-1:0] eff_oh,
  input  logic [OSW-1:0] eff_ow,
  input  logic [OSW-1:0] r_h,
  input  logic [IWW-1:0] q_w,
  input  logic [OSW-1:0] r_w,
  input  logic [AW-1:0]  qh_iw,
  output logic [AW-1:0]  addr,
  output logic           rend,
  output logic           pend
);

  logic [OPW-1:0] out_row, out_col;
  logic [SCW-1:0] sc;
  logic [OSW-1:0] acc_w, acc_h;
  logic [AW-1:0]  row_base;
  logic [OSW:0]   sum_w, sum_h;
  logic           wrap_w, wrap_h;

  assign sum_w  = {1'b0, acc_w} + {1'b0, r_w};
  assign sum_h  = {1'b0, acc_h} + {1'b0, r_h};
  assign wrap_w = (sum_w >= {1'b0, eff_ow});
  assign wrap_h = (sum_h >= {1'b0, eff_oh});

  assign rend = (out_col == OPW'(eff_ow - OSW'(1)));
  assign pend = rend && (out_row == OPW'(eff_oh - OSW'(1)));
  assign addr = row_base + AW'(sc);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_row  <= '0;
      out_col  <= '0;
      sc       <= '0;
      acc_w    <= '0;
      acc_h    <= '0;
      row_base <= '0;
    end else if (step) begin
      if (rend) begin
        out_col <= '0;
        sc      <= '0;
        acc_w   <= '0;
        if (pend) begin
          out_row  <= '0;
          acc_h    <= '0;
          row_base <= '0;
        end else begin
          out_row  <= out_row + OPW'(1);
          acc_h    <= wrap_h ? OSW'(sum_h - {1'b0, eff_oh}) : OSW'(sum_h);
          row_base <= row_base + qh_iw + (wrap_h ? AW'(eff_iw) : AW'(0));
        end
      end else begin
        out_col <= out_col + OPW'(1);
        acc_w   <= wrap_w ? OSW'(sum_w - {1'b0, eff_ow}) : OSW'(sum_w);
        sc      <= sc + SCW'(q_w) + SCW'(wrap_w);
      end
    end
  end

endmodule

// ===== rtl/nnr_checker.sv =====
// Port-level checks for nearest_neighbor_resize_core, attached by bind.
// Uses nnr_pkg for mode codes.
module nnr_checker
  import nnr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                mode,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SAMPLE_W-1:0] pixel,
  input logic                row_end,
  input logic                plane_end
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_plane_ends_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!plane_end || row_end))
    else $error("plane end without row end");

  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && mode == MODE_FETCH, 2))
    else $error("result without a fetch transfer");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result is stalled");

  a_stalled_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(pixel)))
    else $error("stalled result changed");

endmodule

bind nearest_neighbor_resize_core nnr_checker u_nnr_checker (.*);
